FILE: hdl/pmbus_sensor_word_to_milli_units_unit_assert.svh
// Assertion macros shared by the converter RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef PMBUS_SENSOR_WORD_TO_MILLI_UNITS_UNIT_ASSERT_SVH
`define PMBUS_SENSOR_WORD_TO_MILLI_UNITS_UNIT_ASSERT_SVH

// Same-cycle implication.
`define PSWM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pswm: same-cycle check failed");

// Next-cycle implication.
`define PSWM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pswm: next-cycle check failed");

`endif

FILE: hdl/pswm_pkg.sv
`default_nettype none

package pswm_pkg;

  // Supply model classes
  localparam logic [2:0] CLASS_DELTA   = 3'd0;
  localparam logic [2:0] CLASS_LITEON  = 3'd1;
  localparam logic [2:0] CLASS_BEL1100 = 3'd2;
  localparam logic [2:0] CLASS_BEL1500 = 3'd3;
  localparam logic [2:0] CLASS_MURATA  = 3'd4;
  localparam logic [2:0] CLASS_UNKNOWN = 3'd5;

  // Sensor commands
  localparam logic [3:0] CMD_VIN   = 4'd0;
  localparam logic [3:0] CMD_IIN   = 4'd1;
  localparam logic [3:0] CMD_VOUT  = 4'd2;
  localparam logic [3:0] CMD_IOUT  = 4'd3;
  localparam logic [3:0] CMD_TEMP  = 4'd4;
  localparam logic [3:0] CMD_FAN   = 4'd5;
  localparam logic [3:0] CMD_POWER = 4'd6;
  localparam logic [3:0] CMD_VSTBY = 4'd7;
  localparam logic [3:0] CMD_ISTBY = 4'd8;
  localparam logic [3:0] CMD_PSTBY = 4'd9;

  // Configuration register indexes
  localparam logic [1:0] REG_MODEL_LEN  = 2'd0;
  localparam logic [1:0] REG_MODEL_CHAR = 2'd1;
  localparam logic [1:0] REG_MODEL_FAIL = 2'd2;

  // Decoding kinds
  localparam logic [1:0] KIND_EMB = 2'd0;
  localparam logic [1:0] KIND_L11 = 2'd1;
  localparam logic [1:0] KIND_L16 = 2'd2;

  localparam logic [7:0] MAX_MODEL_LEN = 8'd32;
  localparam logic [7:0] CHAR_D = 8'h44;
  localparam logic [7:0] CHAR_E = 8'h45;
  localparam logic [7:0] CHAR_P = 8'h50;
  localparam logic signed [10:0] MILLI = 11'sd1000;

  localparam int VALUE_W = 36;
  localparam int MANT_W  = 17;
  localparam int EXP_W   = 6;
  localparam int PROD_W  = 27;

  typedef logic signed [EXP_W-1:0] exp_t;

  typedef struct packed {
    logic [1:0] kind;
    exp_t       exp;
  } dec_t;

  function automatic logic [2:0] classify(logic [7:0] len, logic [7:0] c);
    logic [2:0] cls;
    if (len == 8'd11 && c == CHAR_E) cls = CLASS_DELTA;
    else if (len == 8'd10 && c == CHAR_P) cls = CLASS_LITEON;
    else if (len == 8'd16 && c == CHAR_P) cls = CLASS_BEL1100;
    else if ((len == 8'd17 || len == 8'd21) && c == CHAR_P) cls = CLASS_BEL1500;
    else if ((len == 8'd22 || len == 8'd25) && c == CHAR_D) cls = CLASS_MURATA;
    else cls = CLASS_UNKNOWN;
    return cls;
  endfunction

  function automatic dec_t l11(exp_t e);
    dec_t d;
    d.kind = KIND_L11;
    d.exp  = e;
    return d;
  endfunction

  // Decoding per model and sensor; anything unlisted uses the embedded exponent
  function automatic dec_t dec_lookup(logic [3:0] cmd, logic [2:0] cls);
    dec_t d;
    d.kind = KIND_EMB;
    d.exp  = '0;
    unique case (cls)
      CLASS_LITEON: begin
        if (cmd == CMD_VOUT || cmd == CMD_VSTBY) begin
          d.kind = KIND_L16;
          d.exp  = -6'sd9;
        end
      end
      CLASS_BEL1100, CLASS_BEL1500: begin
        unique case (cmd)
          CMD_VIN:   d = l11(-6'sd1);
          CMD_IIN:   d = l11(-6'sd6);
          CMD_VOUT:  d = l11(-6'sd6);
          CMD_IOUT:  d = l11((cls == CLASS_BEL1100) ? -6'sd3 : -6'sd2);
          CMD_TEMP:  d = l11(-6'sd3);
          CMD_FAN:   d = l11(6'sd5);
          CMD_POWER: d = l11(6'sd1);
          CMD_VSTBY: d = l11(-6'sd6);
          CMD_ISTBY: d = l11((cls == CLASS_BEL1100) ? -6'sd3 : -6'sd2);
          CMD_PSTBY: d = l11(6'sd1);
          default:   d = d;
        endcase
      end
      CLASS_MURATA: begin
        unique case (cmd)
          CMD_VIN:   d = l11(-6'sd1);
          CMD_IIN:   d = l11(-6'sd5);
          CMD_VOUT:  d = l11(-6'sd6);
          CMD_IOUT:  d = l11(-6'sd2);
          CMD_TEMP:  d = d;
          CMD_FAN:   d = l11(6'sd5);
          CMD_POWER: d = l11(6'sd1);
          CMD_VSTBY: d = l11(-6'sd7);
          CMD_ISTBY: d = l11(-6'sd7);
          CMD_PSTBY: d = l11(-6'sd5);
          default:   d = d;
        endcase
      end
      default: d = d;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/pmbus_sensor_word_to_milli_units_unit.sv
// Converts one PMBus sensor reading per clock, when the output is not stalled,
// into milli-units (plain units for the fan; the raw word passes unscaled for
// an unknown model), with the supply model classified from the configured model
// length and first character. Three register stages (decode and mantissa
// select, multiply by 1000, truncating shift into the output register) take
// one item per cycle while not stalled; an accepted item moves through stage 1,
// stage 2 and the output register in that order. A stall on the output backs up
// stage by stage without losing items.
`default_nettype none

`include "pmbus_sensor_word_to_milli_units_unit_assert.svh"

module pmbus_sensor_word_to_milli_units_unit
  import pswm_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_wr_en,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [7:0]                cfg_wr_data,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [3:0]                in_command,
  input  wire logic [15:0]               in_raw_word,
  input  wire logic                      in_read_failed,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [VALUE_W-1:0]      out_milli_value,
  output logic [2:0]                     out_model_class,
  output logic                           out_error
);

  logic [7:0] model_len_r;
  logic [7:0] model_char_r;
  logic       model_fail_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      model_len_r  <= '0;
      model_char_r <= '0;
      model_fail_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MODEL_LEN:  model_len_r  <= cfg_wr_data;
        REG_MODEL_CHAR: model_char_r <= cfg_wr_data;
        REG_MODEL_FAIL: model_fail_r <= cfg_wr_data[0];
        default:        model_len_r  <= model_len_r;
      endcase
    end
  end

  // Stage ready chain
  logic rdy1, rdy2, rdy3;
  logic s1_valid_r, s2_valid_r, out_valid_r;

  assign rdy3     = !out_valid_r || !out_stall;
  assign rdy2     = !s2_valid_r || rdy3;
  assign rdy1     = !s1_valid_r || rdy2;
  assign in_stall = !rdy1;

  // Stage 1: classify, look up decoding, pick mantissa and exponent
  logic                      model_bad;
  logic [2:0]                cls_c;
  logic                      err_c;
  dec_t                      dec_c;
  logic signed [MANT_W-1:0]  mant_c;
  exp_t                      exp_c;
  logic                      unit_c;

  always_comb begin
    model_bad = model_fail_r || (model_len_r > MAX_MODEL_LEN);
    cls_c     = model_bad ? CLASS_UNKNOWN : classify(model_len_r, model_char_r);
    err_c     = model_bad || in_read_failed || (in_command > CMD_PSTBY);
    dec_c     = dec_lookup(in_command, cls_c);
    unit_c    = 1'b0;
    if (err_c) begin
      mant_c = '0;
      exp_c  = '0;
      unit_c = 1'b1;
    end else if (cls_c == CLASS_UNKNOWN) begin
      // pass the raw word through unscaled
      mant_c = {1'b0, in_raw_word};
      exp_c  = '0;
      unit_c = 1'b1;
    end else begin
      if (dec_c.kind == KIND_L16) begin
        mant_c = {1'b0, in_raw_word};
      end else begin
        mant_c = {{(MANT_W-11){in_raw_word[10]}}, in_raw_word[10:0]};
      end
      if (dec_c.kind == KIND_L16 || (dec_c.kind == KIND_L11 && dec_c.exp != '0)) begin
        exp_c = dec_c.exp;
      end else begin
        exp_c = {in_raw_word[15], in_raw_word[15:11]};
      end
      // fan: x*1000 scaled then /1000 equals the mantissa scaled directly
      unit_c = (in_command == CMD_FAN);
    end
  end

  logic signed [MANT_W-1:0] s1_mant_r;
  exp_t                     s1_exp_r;
  logic                     s1_unit_r;
  logic [2:0]               s1_cls_r;
  logic                     s1_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (rdy1) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_mant_r <= mant_c;
      s1_exp_r  <= exp_c;
      s1_unit_r <= unit_c;
      s1_cls_r  <= cls_c;
      s1_err_r  <= err_c;
    end
  end

  // Stage 2: multiply by 1000 (or 1)
  logic signed [10:0]       factor_c;
  logic signed [PROD_W-1:0] prod_c;

  assign factor_c = s1_unit_r ? 11'sd1 : MILLI;
  assign prod_c   = PROD_W'(s1_mant_r) * PROD_W'(factor_c);

  logic signed [PROD_W-1:0] s2_prod_r;
  exp_t                     s2_exp_r;
  logic [2:0]               s2_cls_r;
  logic                     s2_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (rdy2) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_prod_r <= prod_c;
      s2_exp_r  <= s1_exp_r;
      s2_cls_r  <= s1_cls_r;
      s2_err_r  <= s1_err_r;
    end
  end

  // Stage 3: shift by the exponent, truncating toward zero on right shifts
  localparam int SH_W = PROD_W + 15;

  logic signed [SH_W-1:0] ext_c;
  logic [EXP_W-1:0]       neg_e_c;
  logic [4:0]             rsh_c;
  logic signed [SH_W-1:0] bias_c;
  logic signed [SH_W-1:0] shifted_c;

  always_comb begin
    ext_c   = {{(SH_W-PROD_W){s2_prod_r[PROD_W-1]}}, s2_prod_r};
    neg_e_c = EXP_W'(-s2_exp_r);
    rsh_c   = neg_e_c[4:0];
    bias_c  = '0;
    if (s2_exp_r[EXP_W-1]) begin
      if (s2_prod_r[PROD_W-1]) begin
        bias_c = (SH_W'(1) << rsh_c) - SH_W'(1);
      end
      shifted_c = (ext_c + bias_c) >>> rsh_c;
    end else begin
      shifted_c = ext_c <<< s2_exp_r[3:0];
    end
  end

  logic signed [VALUE_W-1:0] out_value_r;
  logic [2:0]                out_cls_r;
  logic                      out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy3) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      out_value_r <= shifted_c[VALUE_W-1:0];
      out_cls_r   <= s2_cls_r;
      out_err_r   <= s2_err_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_milli_value = out_value_r;
  assign out_model_class = out_cls_r;
  assign out_error       = out_err_r;

  `PSWM_ASSERT_IMP(a_err_zero, out_valid && out_error, out_milli_value == '0)
  `PSWM_ASSERT_IMP(a_model_bad_unknown,
                   out_valid && (model_fail_r || model_len_r > MAX_MODEL_LEN),
                   out_error && out_model_class == CLASS_UNKNOWN)
  `PSWM_ASSERT_IMP(a_unknown_passthru,
                   out_valid && !out_error && out_model_class == CLASS_UNKNOWN,
                   out_milli_value[VALUE_W-1:16] == '0)
  `PSWM_ASSERT_NXT(a_s1_hold, s1_valid_r && !rdy2, s1_valid_r && $stable(s1_mant_r))

endmodule

`default_nettype wire
